### rtl/ashc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ashc_pkg;

	localparam int TIME_W     = 16;
	localparam int LOC_W      = 10;
	localparam int FILL_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLUS_SZ  = 2'd2;

	localparam logic signed [TIME_W-1:0] MIN_TIME_RST = 16'sd0;
	localparam logic signed [TIME_W-1:0] MAX_TIME_RST = 16'sd704;
	localparam logic [FILL_W-1:0]        MAX_SZ_RST   = 4'd4;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_DEAD   = 2'd1,
		ST_LATE   = 2'd2
	} status_t;

	// classified hit, minus the strip whose width is a top-level parameter
	typedef struct packed {
		logic             ev;
		status_t          status;
		logic [LOC_W-1:0] loc;
	} hit_cls_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] min_time;
		logic signed [TIME_W-1:0] max_time;
		logic [FILL_W-1:0]        max_size;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/ashc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ashc_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	cnt_in_range : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count beyond depth");

	wr_when_full_blocked : assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_rd |=> $stable(wr_ptr_q))
		else $error("write pointer moved while full");

	ptr_gap_matches_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ on an empty queue");

endmodule

`default_nettype wire

### rtl/ashc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ashc_front #(
	parameter int STRIP_BITS = 8
) (
	input  wire logic                          push,
	output logic                               full,
	input  wire ashc_pkg::cfg_t                cfg,
	input  wire logic                          event_start,
	input  wire logic                          dead,
	input  wire logic signed [ashc_pkg::TIME_W-1:0] hit_time,
	input  wire logic                          arm,
	input  wire logic [1:0]                    station,
	input  wire logic [2:0]                    octant,
	input  wire logic                          half_octant,
	input  wire logic [2:0]                    radial_segment,
	input  wire logic [STRIP_BITS-1:0]         strip,
	output logic                               q_push,
	output logic [$bits(ashc_pkg::hit_cls_t)+STRIP_BITS-1:0] q_data,
	input  wire logic                          q_full
);

	import ashc_pkg::*;

	hit_cls_t cls;

	always_comb begin
		cls.ev  = event_start;
		cls.loc = {radial_segment, half_octant, octant, station, arm};
		// dead outranks the time window
		if (dead) begin
			cls.status = ST_DEAD;
		end else if (hit_time < cfg.min_time || hit_time > cfg.max_time) begin
			cls.status = ST_LATE;
		end else begin
			cls.status = ST_ACCEPT;
		end
	end

	assign full   = q_full;
	assign q_push = push && !q_full;
	assign q_data = {cls, strip};

endmodule

`default_nettype wire

### rtl/ashc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ashc_back #(
	parameter int STRIP_BITS         = 8,
	parameter int CLUSTER_INDEX_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [ashc_pkg::FILL_W-1:0]     max_size,
	input  wire logic [$bits(ashc_pkg::hit_cls_t)+STRIP_BITS-1:0] q_data,
	input  wire logic                            q_empty,
	output logic                                 q_pop,
	input  wire logic                            pop,
	output logic                                 empty,
	output logic [1:0]                           status,
	output logic                                 new_cluster,
	output logic [CLUSTER_INDEX_BITS-1:0]        cluster_index,
	output logic [ashc_pkg::FILL_W-1:0]          fill_count,
	output logic                                 index_overflow
);

	import ashc_pkg::*;

	localparam logic [CLUSTER_INDEX_BITS-1:0] IDX_MAX = '1;

	hit_cls_t                cls;
	logic [STRIP_BITS-1:0]   strip_h;

	logic                    have_q;
	logic [LOC_W-1:0]        loc_q;
	logic [STRIP_BITS-1:0]   prev_strip_q;
	logic [FILL_W-1:0]       fill_q;
	logic [CLUSTER_INDEX_BITS-1:0] count_q;

	logic                    have_d;
	logic [LOC_W-1:0]        loc_d;
	logic [STRIP_BITS-1:0]   prev_strip_d;
	logic [FILL_W-1:0]       fill_d;
	logic [CLUSTER_INDEX_BITS-1:0] count_d;

	logic                    out_valid_q;
	status_t                 status_q;
	logic                    new_q;
	logic [CLUSTER_INDEX_BITS-1:0] idx_q;
	logic [FILL_W-1:0]       res_fill_q;
	logic                    ovf_q;

	logic                    res_new;
	logic [CLUSTER_INDEX_BITS-1:0] res_idx;
	logic [FILL_W-1:0]       res_fill;
	logic                    res_ovf;
	logic                    adjacent;
	logic                    joins;

	assign {cls, strip_h} = q_data;

	// output slot is free, or is being drained this cycle
	assign q_pop = !q_empty && (!out_valid_q || pop);

	always_comb begin
		// event start clears the state before the hit is looked at
		have_d       = cls.ev ? 1'b0 : have_q;
		loc_d        = cls.ev ? '0 : loc_q;
		prev_strip_d = cls.ev ? '0 : prev_strip_q;
		fill_d       = cls.ev ? '0 : fill_q;
		count_d      = cls.ev ? '0 : count_q;

		adjacent = ({1'b0, strip_h} == {1'b0, prev_strip_d} + 1'b1) ||
			({1'b0, prev_strip_d} == {1'b0, strip_h} + 1'b1);
		joins = have_d && (cls.loc == loc_d) && adjacent && (fill_d < max_size);

		res_new  = 1'b0;
		res_idx  = '0;
		res_fill = '0;
		res_ovf  = 1'b0;

		if (cls.status == ST_ACCEPT) begin
			if (joins) begin
				fill_d = fill_d + 1'b1;
			end else begin
				res_new = 1'b1;
				if (!have_d) begin
					count_d = '0;
				end else if (count_d == IDX_MAX) begin
					res_ovf = 1'b1;
				end else begin
					count_d = count_d + 1'b1;
				end
				fill_d = FILL_W'(1);
			end
			have_d       = 1'b1;
			loc_d        = cls.loc;
			prev_strip_d = strip_h;
			res_idx      = count_d;
			res_fill     = fill_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q       <= 1'b0;
			loc_q        <= '0;
			prev_strip_q <= '0;
			fill_q       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				have_q       <= have_d;
				loc_q        <= loc_d;
				prev_strip_q <= prev_strip_d;
				fill_q       <= fill_d;
				count_q      <= count_d;
				out_valid_q  <= 1'b1;
			end else if (pop) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q   <= cls.status;
			new_q      <= res_new;
			idx_q      <= res_idx;
			res_fill_q <= res_fill;
			ovf_q      <= res_ovf;
		end
	end

	assign empty          = !out_valid_q;
	assign status         = status_q;
	assign new_cluster    = new_q;
	assign cluster_index  = idx_q;
	assign fill_count     = res_fill_q;
	assign index_overflow = ovf_q;

	ovf_only_on_new : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ovf_q |-> new_q && (idx_q == IDX_MAX))
		else $error("overflow flagged without a saturated new cluster");

	reject_is_blank : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_ACCEPT) |->
			!new_q && !ovf_q && (idx_q == '0) && (res_fill_q == '0))
		else $error("rejected hit carries cluster data");

	accept_has_fill : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_ACCEPT) |-> (res_fill_q != '0) && have_q)
		else $error("accepted hit with empty cluster");

	new_restarts_fill : assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && res_new |=> (fill_q == FILL_W'(1)))
		else $error("new cluster did not restart the fill count");

endmodule

`default_nettype wire

### rtl/adjacent_strip_hit_clusterer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              beat contents
// hit       in         push / full            event_start dead hit_time location strip
// result    out        empty / pop            status new_cluster cluster_index fill_count
//                                             index_overflow
// config    in         cfg_we (no wait)       cfg_index cfg_data
//
// one hit per cycle sustained while results are popped; a hit goes through the queue and
// then the result register; the front classifies into a two-beat queue, the back updates
// the cluster state and holds one result register; full rises once the queue holds two
// beats behind an unpopped result
// arst_n clears queue, result register and clustering state, and loads register defaults

module adjacent_strip_hit_clusterer #(
	parameter int STRIP_BITS         = 8,
	parameter int CLUSTER_INDEX_BITS = 12
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic                                event_start,
	input  wire logic                                dead,
	input  wire logic signed [ashc_pkg::TIME_W-1:0]  hit_time,
	input  wire logic                                arm,
	input  wire logic [1:0]                          station,
	input  wire logic [2:0]                          octant,
	input  wire logic                                half_octant,
	input  wire logic [2:0]                          radial_segment,
	input  wire logic [STRIP_BITS-1:0]               strip,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [1:0]                               status,
	output logic                                     new_cluster,
	output logic [CLUSTER_INDEX_BITS-1:0]            cluster_index,
	output logic [ashc_pkg::FILL_W-1:0]              fill_count,
	output logic                                     index_overflow,
	input  wire logic                                cfg_we,
	input  wire logic [ashc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ashc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import ashc_pkg::*;

	localparam int Q_W = $bits(hit_cls_t) + STRIP_BITS;

	cfg_t           cfg_q;
	logic           q_push;
	logic [Q_W-1:0] q_wdata;
	logic           q_full;
	logic           q_pop;
	logic [Q_W-1:0] q_rdata;
	logic           q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_time <= MIN_TIME_RST;
			cfg_q.max_time <= MAX_TIME_RST;
			cfg_q.max_size <= MAX_SZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_TIME:    cfg_q.min_time <= cfg_data;
				REG_MAX_TIME:    cfg_q.max_time <= cfg_data;
				REG_MAX_CLUS_SZ: cfg_q.max_size <= cfg_data[FILL_W-1:0];
				default: ;
			endcase
		end
	end

	ashc_front #(
		.STRIP_BITS (STRIP_BITS)
	) u_front (
		.push           (push),
		.full           (full),
		.cfg            (cfg_q),
		.event_start    (event_start),
		.dead           (dead),
		.hit_time       (hit_time),
		.arm            (arm),
		.station        (station),
		.octant         (octant),
		.half_octant    (half_octant),
		.radial_segment (radial_segment),
		.strip          (strip),
		.q_push         (q_push),
		.q_data         (q_wdata),
		.q_full         (q_full)
	);

	ashc_fifo #(
		.DATA_W (Q_W),
		.DEPTH  (2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	ashc_back #(
		.STRIP_BITS         (STRIP_BITS),
		.CLUSTER_INDEX_BITS (CLUSTER_INDEX_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_size       (cfg_q.max_size),
		.q_data         (q_rdata),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.new_cluster    (new_cluster),
		.cluster_index  (cluster_index),
		.fill_count     (fill_count),
		.index_overflow (index_overflow)
	);

endmodule

`default_nettype wire
